>>> rtl/gn_pkg.sv
// gn_pkg: shared widths, register indexes, saturation limits and the command and
// status structs of the group normalizer. No dependencies.
package gn_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FILL_W   = 7;
  localparam int EPS_W    = 32;
  localparam int SUM_W    = 23;
  localparam int D_W      = 24;
  localparam int MAG_W    = 23;
  localparam int SQR_W    = 46;
  localparam int ACC_W    = 52;
  localparam int N3_W     = 21;
  localparam int DIVQ_W   = 32;
  localparam int DEN_W    = 32;
  localparam int NUM_W    = 43;
  localparam int RAD_W    = 49;
  localparam int ROOT_W   = 25;
  localparam int CNT_W    = 5;

  localparam logic [CNT_W-1:0] VAR_TOP  = 5'd31;
  localparam logic [CNT_W-1:0] OUT_TOP  = 5'd16;
  localparam logic [CNT_W-1:0] ROOT_TOP = 5'd24;

  localparam logic REG_GROUP_SIZE = 1'b0;
  localparam logic REG_EPSILON    = 1'b1;

  localparam logic [FILL_W-1:0]   GROUP_SIZE_RST = 7'd64;
  localparam logic [EPS_W-1:0]    EPSILON_RST    = 32'd1;
  localparam logic [SAMPLE_W-1:0] SAT_POS        = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAT_NEG        = 16'h8000;
  localparam logic [16:0]         Q_LIMIT        = 17'd32768;

  typedef struct packed {
    logic load;
    logic sq_run;
    logic var_start;
    logic sqrt_start;
    logic den_load;
    logic out_rd;
    logic out_d;
    logic out_prep;
    logic out_start;
    logic emit;
  } gn_cmd_t;

  typedef struct packed {
    logic close;
    logic sq_done;
    logic div_done;
    logic sqrt_done;
    logic bypass;
    logic last;
    logic out_free;
  } gn_status_t;

endpackage

>>> rtl/gn_div.sv
// gn_div: iterative restoring divider, one quotient bit per cycle, from a
// selectable top bit down. Depends on gn_pkg.
module gn_div import gn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ACC_W-1:0]  dividend,
  input  logic [DEN_W-1:0]  divisor,
  input  logic [CNT_W-1:0]  top,
  output logic [DIVQ_W-1:0] quotient,
  output logic              done
);

  localparam int DSH_W = DEN_W + 31;

  logic [ACC_W-1:0] rem;
  logic [DSH_W-1:0] dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             fits;

  assign fits = DSH_W'(rem) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= DSH_W'(divisor) << top;
      cnt      <= top;
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - ACC_W'(dsh);
      end
      quotient <= {quotient[DIVQ_W-2:0], fits};
      dsh      <= dsh >> 1;
      cnt      <= cnt - 1'b1;
    end
  end

endmodule

>>> rtl/gn_ctrl.sv
// gn_ctrl: sequencer of the group normalizer, load, square-sum pass, variance
// divide, root, and the per-sample output pass. Depends on gn_pkg.
module gn_ctrl import gn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  gn_status_t status,
  output gn_cmd_t    cmd
);

  typedef enum logic [9:0] {
    LOAD   = 10'b0000000001,
    SQ     = 10'b0000000010,
    VDIV   = 10'b0000000100,
    ROOT   = 10'b0000001000,
    ORD    = 10'b0000010000,
    OD     = 10'b0000100000,
    OPREP  = 10'b0001000000,
    OSTART = 10'b0010000000,
    ODIV   = 10'b0100000000,
    OEMIT  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      LOAD: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
        if (s_tvalid && status.close) state_next = SQ;
      end
      SQ: begin
        cmd.sq_run = 1'b1;
        if (status.sq_done) begin
          cmd.var_start = 1'b1;
          state_next    = VDIV;
        end
      end
      VDIV: begin
        if (status.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = ROOT;
        end
      end
      ROOT: begin
        if (status.sqrt_done) begin
          cmd.den_load = 1'b1;
          state_next   = ORD;
        end
      end
      ORD: begin
        cmd.out_rd = 1'b1;
        state_next = OD;
      end
      OD: begin
        cmd.out_d  = 1'b1;
        state_next = OPREP;
      end
      OPREP: begin
        cmd.out_prep = 1'b1;
        state_next   = OSTART;
      end
      OSTART: begin
        if (status.bypass) begin
          state_next = OEMIT;
        end else begin
          cmd.out_start = 1'b1;
          state_next    = ODIV;
        end
      end
      ODIV: begin
        if (status.div_done) state_next = OEMIT;
      end
      OEMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.last ? LOAD : ORD;
        end
      end
      default: state_next = LOAD;
    endcase
  end

endmodule

>>> rtl/gn_datapath.sv
// gn_datapath: config registers, sample store, sums, root, divider and the
// output register of the group normalizer. Depends on gn_pkg and gn_div.
module gn_datapath import gn_pkg::*; #(
  parameter int MAX_GROUP = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [EPS_W-1:0]           cfg_data,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  gn_cmd_t                    cmd,
  output gn_status_t                 status,
  input  logic                       m_tready,
  output logic                       m_tvalid,
  output logic [SAMPLE_W-1:0]        normalized,
  output logic                       group_end
);

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic [FILL_W-1:0]          group_size;
  logic [EPS_W-1:0]           epsilon;
  logic [FILL_W-1:0]          fill;
  logic [FILL_W-1:0]          size_eff;
  logic [FILL_W-1:0]          fill_inc;
  logic signed [SAMPLE_W-1:0] mem [MAX_GROUP];
  logic signed [SAMPLE_W-1:0] rdata;
  logic signed [SUM_W-1:0]    sum;
  logic [FILL_W-1:0]          n;
  logic [13:0]                nn;
  logic [N3_W-1:0]            n3;
  logic [FILL_W-1:0]          idx;
  logic                       issue;
  logic                       v1, v2, v3;
  logic signed [D_W-1:0]      prod;
  logic signed [D_W-1:0]      dcalc;
  logic signed [D_W-1:0]      d1;
  logic [MAG_W-1:0]           dmag;
  logic [SQR_W-1:0]           sqr;
  logic [ACC_W-1:0]           acc;
  logic [RAD_W-1:0]           rad;
  logic [RAD_W-1:0]           res;
  logic [RAD_W-1:0]           sbit;
  logic [RAD_W:0]             trial;
  logic [CNT_W-1:0]           scnt;
  logic                       sbusy;
  logic                       sdone;
  logic [DEN_W-1:0]           den;
  logic [NUM_W-1:0]           numer_c;
  logic [NUM_W-1:0]           numer;
  logic                       neg, zro, ovf;
  logic [DIVQ_W-1:0]          dq;
  logic                       ddone;
  logic [SAMPLE_W-1:0]        result;
  logic [16:0]                q17;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GROUP_SIZE_RST;
      epsilon    <= EPSILON_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GROUP_SIZE: group_size <= cfg_data[FILL_W-1:0];
        REG_EPSILON:    epsilon    <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (group_size == '0) size_eff = FILL_W'(1);
    else if (group_size > FILL_W'(MAX_GROUP)) size_eff = FILL_W'(MAX_GROUP);
    else size_eff = group_size;
  end

  assign fill_inc     = fill + FILL_W'(1);
  assign status.close = fill_inc >= size_eff;

  // load
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.load) begin
      fill <= status.close ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum <= (fill == '0) ? SUM_W'(sample) : sum + SUM_W'(sample);
      if (status.close) n <= fill_inc;
    end
    nn <= 14'(n) * 14'(n);
    n3 <= N3_W'(nn) * N3_W'(n);
  end

  // sample store
  assign issue = cmd.sq_run && (idx < n);

  always_ff @(posedge clk) begin
    if (cmd.load) mem[fill[AW-1:0]] <= sample;
    if (issue || cmd.out_rd) rdata <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && status.close) idx <= '0;
    else if (issue) idx <= idx + FILL_W'(1);
    else if (cmd.den_load) idx <= '0;
    else if (cmd.emit && !status.last) idx <= idx + FILL_W'(1);
  end

  assign status.last = idx == (n - FILL_W'(1));

  // centred value and square sum
  assign prod  = D_W'($signed({1'b0, n}) * rdata);
  assign dcalc = prod - D_W'(sum);
  assign dmag  = d1[D_W-1] ? MAG_W'(-d1) : MAG_W'(d1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 || cmd.out_d) d1 <= dcalc;
    if (v2) sqr <= SQR_W'(dmag) * SQR_W'(dmag);
    if (cmd.load && status.close) acc <= '0;
    else if (v3) acc <= acc + ACC_W'(sqr);
  end

  assign status.sq_done = cmd.sq_run && (idx == n) && !v1 && !v2 && !v3;

  // square root, one result bit per step, two radicand bits per step
  assign trial = (RAD_W + 1)'(res) + (RAD_W + 1)'(sbit);

  always_ff @(posedge clk) begin
    if (rst) begin
      sbusy <= 1'b0;
      sdone <= 1'b0;
    end else begin
      sdone <= 1'b0;
      if (cmd.sqrt_start) begin
        sbusy <= 1'b1;
      end else if (sbusy && scnt == '0) begin
        sbusy <= 1'b0;
        sdone <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rad  <= {(EPS_W + 1)'(dq) + (EPS_W + 1)'(epsilon), 16'd0};
      res  <= '0;
      sbit <= RAD_W'(1) << (RAD_W - 1);
      scnt <= ROOT_TOP;
    end else if (sbusy) begin
      if ((RAD_W + 1)'(rad) >= trial) begin
        rad <= rad - RAD_W'(trial);
        res <= (res >> 1) + sbit;
      end else begin
        res <= res >> 1;
      end
      sbit <= sbit >> 2;
      scnt <= scnt - 1'b1;
    end
  end

  assign status.sqrt_done = sdone;

  // output pass
  assign numer_c = {dmag, 20'd0} + NUM_W'(den[DEN_W-1:1]);

  always_ff @(posedge clk) begin
    if (cmd.den_load) den <= DEN_W'(DEN_W'(n) * DEN_W'(res[ROOT_W-1:0]));
    if (cmd.out_prep) begin
      neg   <= d1[D_W-1];
      zro   <= d1 == '0;
      numer <= numer_c;
      ovf   <= (DEN_W + 17)'(numer_c) >= {den, 17'd0};
    end
  end

  assign status.bypass = zro || ovf;

  gn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.var_start || cmd.out_start),
    .dividend (cmd.var_start ? acc : ACC_W'(numer)),
    .divisor  (cmd.var_start ? DEN_W'(n3) : den),
    .top      (cmd.var_start ? VAR_TOP : OUT_TOP),
    .quotient (dq),
    .done     (ddone)
  );

  assign status.div_done = ddone;

  assign q17 = dq[16:0];

  always_comb begin
    if (zro) result = '0;
    else if (ovf) result = neg ? SAT_NEG : SAT_POS;
    else if (neg) result = (q17 >= Q_LIMIT) ? SAT_NEG : SAMPLE_W'(17'd0 - q17);
    else result = (q17 >= Q_LIMIT) ? SAT_POS : q17[SAMPLE_W-1:0];
  end

  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      normalized <= result;
      group_end  <= status.last;
    end
  end

endmodule

>>> rtl/group_normalizer_core.sv
// group_normalizer_core: group normalization of Q8.8 samples into Q4.12
// results. Instantiates gn_ctrl and gn_datapath; depends on gn_pkg.
//
// Usage:
//   Config: cfg_we writes cfg_data to register cfg_addr (0 group_size,
//   1 epsilon) at the clock edge; write only while the block is idle.
//   Input stream s_*: one signed Q8.8 sample per transaction. Samples are
//   stored at one per cycle; the transaction that completes a group starts
//   the computation and s_tready stays low until the last result of the
//   group is in the output register.
//   Output stream m_*: one Q4.12 result per stored sample, in input order,
//   m_tlast on the last result of the group.
// Sequence per group:
//   load; square-sum pass over the store; variance divide; root; then per
//   result a store read, the centred value, a prepare step and a divide on
//   the bit-serial divider, skipped when the value is zero or saturates.
//   Throughput is set by the shared one-bit-per-cycle divider.
// Reset: rst (synchronous) drops any partial group, restores group_size 64
//   and epsilon 1, and empties the output register.
// Stall: a result waits in the output register while m_tready is low; the
//   sequencer holds on the next result until the register frees up.
module group_normalizer_core import gn_pkg::*; #(
  parameter int MAX_GROUP = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [EPS_W-1:0]    cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] normalized
  output logic                m_tlast
);

  gn_cmd_t    cmd;
  gn_status_t status;

  gn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gn_datapath #(
    .MAX_GROUP (MAX_GROUP)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .sample     ($signed(s_tdata)),
    .cmd        (cmd),
    .status     (status),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .normalized (m_tdata),
    .group_end  (m_tlast)
  );

endmodule

>>> verif/testbench.sv
// testbench: self-checking bench for group_normalizer_core, with directed groups then
// random phases of group size and epsilon under random stalls on both streams.
// Depends on gn_pkg and the group_normalizer_core RTL.
`timescale 1ns / 1ps

typedef struct packed {
  logic [15:0] value;
  logic        last;
} norm_result_t;

class gn_scoreboard;
  shortint        store[64];
  int             fill;
  int unsigned    size_reg;
  int unsigned    eps_reg;
  norm_result_t   expected_norm[$];
  int             mismatches;
  int             results_seen;
  int             groups_closed;

  function new();
    fill = 0;
    size_reg = 64;
    eps_reg = 1;
    mismatches = 0;
    results_seen = 0;
    groups_closed = 0;
  endfunction

  function void write_reg(logic addr, logic [31:0] data);
    if (addr == gn_pkg::REG_GROUP_SIZE) size_reg = data[6:0];
    else eps_reg = data;
  endfunction

  function longint unsigned root64(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function logic [15:0] scale_sat(longint d, longint unsigned den);
    longint unsigned mag;
    longint q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    if (d == 0) return 16'h0000;
    if (den == 0) return (d > 0) ? 16'h7fff : 16'h8000;
    mag = ((mag << 20) + den / 2) / den;
    if (mag > 40000) mag = 40000;
    q = (d < 0) ? -longint'(mag) : longint'(mag);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function void note_sample(logic [15:0] x);
    int unsigned eff;
    longint sum;
    longint d;
    longint unsigned sq;
    longint unsigned varq;
    longint unsigned r;
    longint unsigned den;
    norm_result_t res;
    eff = size_reg;
    if (eff == 0) eff = 1;
    if (eff > 64) eff = 64;
    if (fill < 64) begin
      store[fill] = shortint'(x);
      fill++;
    end
    if (fill < eff) return;
    sum = 0;
    sq = 0;
    for (int i = 0; i < fill; i++) sum += longint'(store[i]);
    for (int i = 0; i < fill; i++) begin
      d = longint'(fill) * longint'(store[i]) - sum;
      sq += longint'(d * d);
    end
    varq = sq / (longint'(fill) * fill * fill);
    r = root64((varq + longint'(eps_reg)) << 16);
    den = longint'(fill) * r;
    for (int i = 0; i < fill; i++) begin
      d = longint'(fill) * longint'(store[i]) - sum;
      res.value = scale_sat(d, den);
      res.last = (i + 1 == fill);
      expected_norm = {expected_norm, res};
    end
    fill = 0;
    groups_closed++;
  endfunction

  function void check_result(logic [15:0] value, logic last);
    norm_result_t exp_r;
    results_seen++;
    if (expected_norm.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: normalized %h last %b", value, last);
      return;
    end
    exp_r = expected_norm.pop_front();
    if (value !== exp_r.value || last !== exp_r.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected normalized %h last %b, got %h last %b",
                 exp_r.value, exp_r.last, value, last);
    end
  endfunction

  function int pending();
    return expected_norm.size();
  endfunction
endclass

module testbench;
  import gn_pkg::*;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic                cfg_addr;
  logic [EPS_W-1:0]    cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata;   // [15:0] sample
  logic                m_tvalid;
  logic                m_tready;
  logic [SAMPLE_W-1:0] m_tdata;   // [15:0] normalized
  logic                m_tlast;

  gn_scoreboard sb;
  int  samples_sent;
  int  reg_writes;
  bit  no_gaps;

  group_normalizer_core DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function logic [15:0] pick_sample(int mode, logic [15:0] base);
    case (mode)
      0: return 16'($urandom);
      1: return base + 16'($urandom_range(0, 15)) - 16'd8;
      2: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 511)) - 16'd256;
    endcase
  endfunction

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [31:0] data);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.write_reg(addr, data);
    reg_writes++;
  endtask

  task automatic send_sample(logic [15:0] x);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(x);
    samples_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // output side back-pressure
  initial begin
    int run;
    m_tready = 1'b0;
    forever begin
      run = $urandom_range(1, 30);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (!no_gaps) begin
        m_tready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                            : $urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int eff;
    int groups;
    int mode;
    int sel;
    logic [15:0] base;
    sb = new();
    samples_sent = 0;
    reg_writes = 0;
    no_gaps = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and constant group
    write_reg(REG_GROUP_SIZE, 32'd4);
    send_sample(16'h7fff); send_sample(16'h8000); send_sample(16'h0000); send_sample(16'h0001);
    send_sample(16'h0005); send_sample(16'h0005); send_sample(16'h0005); send_sample(16'h0005);
    // single-sample groups, size zero behaves as one
    write_reg(REG_GROUP_SIZE, 32'd1);
    send_sample(16'h8000);
    write_reg(REG_GROUP_SIZE, 32'd0);
    send_sample(16'h1234);
    // zero root: variance floors to zero with no epsilon
    write_reg(REG_GROUP_SIZE, 32'd2);
    write_reg(REG_EPSILON, 32'd0);
    send_sample(16'h0000); send_sample(16'h0001);
    write_reg(REG_GROUP_SIZE, 32'd3);
    write_reg(REG_EPSILON, 32'hffffffff);
    send_sample(16'h7fff); send_sample(16'h8000); send_sample(16'h1234);
    // size lowered while a group is partly filled
    write_reg(REG_EPSILON, 32'd1);
    write_reg(REG_GROUP_SIZE, 32'd8);
    repeat (5) send_sample(16'($urandom));
    write_reg(REG_GROUP_SIZE, 32'd3);
    send_sample(16'($urandom));

    // random phases
    while (samples_sent < 320) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) eff = 64;
      else if (sel < 6) eff = 127;
      else if (sel < 8) eff = 100;
      else eff = $urandom_range(0, 16);
      write_reg(REG_GROUP_SIZE, 32'(eff));
      case ($urandom_range(0, 4))
        0: write_reg(REG_EPSILON, 32'd0);
        1: write_reg(REG_EPSILON, 32'hffffffff);
        2: write_reg(REG_EPSILON, 32'($urandom_range(0, 300)));
        default: write_reg(REG_EPSILON, $urandom);
      endcase
      if (eff == 0) eff = 1;
      if (eff > 64) eff = 64;
      no_gaps = ($urandom_range(0, 4) == 0);
      groups = (eff >= 32) ? 1 : $urandom_range(1, 3);
      base = 16'($urandom);
      repeat (groups) begin
        mode = $urandom_range(0, 3);
        repeat (eff - sb.fill) send_sample(pick_sample(mode, base));
      end
      // leave a partial group behind now and then
      if (eff > 1 && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, eff - 1)) send_sample(16'($urandom));
    end

    s_tvalid <= 1'b0;
    no_gaps = 0;
    while (sb.pending() != 0) @(posedge clk);
    // flush any partial group so that nothing stays held
    if (sb.fill != 0) begin
      write_reg(REG_GROUP_SIZE, 32'd1);
      send_sample(16'h0042);
      s_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
    end
    repeat (100) @(posedge clk);

    $display("covered %0d samples in %0d groups, %0d results, %0d register writes",
             samples_sent, sb.groups_closed, sb.results_seen, reg_writes);
    $display("mismatches: %0d, results still expected: %0d", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/gn_pkg.sv
rtl/gn_div.sv
rtl/gn_ctrl.sv
rtl/gn_datapath.sv
rtl/group_normalizer_core.sv
verif/testbench.sv
